FILE: hdl/bdq_pkg.sv
// Shared types, request and status codes for the bounded deque unit.
package bdq_pkg;

  localparam int REQ_W  = 4;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd4;
  localparam logic [REQ_W-1:0] REQ_DELETE     = 4'd5;
  localparam logic [REQ_W-1:0] REQ_LIST_ALL   = 4'd6;
  localparam logic [REQ_W-1:0] REQ_LIST_FIRST = 4'd7;
  localparam logic [REQ_W-1:0] REQ_LIST_LAST  = 4'd8;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] item_value;
    logic [STAT_W-1:0]       status;
    logic                    last_flag;
  } out_item_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic latch;        // capture the accepted request
    logic update;       // push, pop or clear
    logic scan_init;    // start a delete scan
    logic scan_step;    // step the delete scan
    logic scan_finish;  // close the delete
    logic list_init;    // set up a listing window
    logic rd_issue;     // read one listed entry
    logic load_resp;    // load a status result
    logic load_item;    // load a listed entry
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             slot_free;
    logic             list_empty;
    logic             scan_done;
    logic             list_last;
  } sts_t;

endpackage

FILE: hdl/bdq_ctrl.sv
// Request sequencer of the bounded deque unit.
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RESP  = 3'd2;
  localparam logic [2:0] S_LRD   = 3'd3;
  localparam logic [2:0] S_LEMIT = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.req) inside
          REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_POP_FRONT, REQ_POP_BACK, REQ_CLEAR: begin
            cmd.update = 1'b1;
            state_nxt  = S_RESP;
          end
          REQ_DELETE: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
          REQ_LIST_ALL, REQ_LIST_FIRST, REQ_LIST_LAST: begin
            cmd.list_init = 1'b1;
            state_nxt     = sts.list_empty ? S_RESP : S_LRD;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RESP: begin
        if (sts.slot_free) begin
          cmd.load_resp = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LRD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_LEMIT;
      end
      S_LEMIT: begin
        if (sts.slot_free) begin
          cmd.load_item = 1'b1;
          state_nxt     = sts.list_last ? S_IDLE : S_LRD;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.scan_finish = 1'b1;
          state_nxt       = S_RESP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/bdq_dpath.sv
// Datapath of the bounded deque unit: circular entry memory, pointers, output register.
module bdq_dpath
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]                head_r, head_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         found_r, found_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]            resp_r, resp_nxt;
  logic [REQ_W-1:0]             req_r;
  logic signed [VAL_W-1:0]      op_r;
  logic [CW-1:0]                ptr_r, lim_r, rd_idx_r;
  logic signed [DATA_WIDTH-1:0] rd_data_r;
  out_item_t                    out_data_r;

  logic signed [DATA_WIDTH-1:0] key;
  logic [AW-1:0]                head_dec, head_inc, rd_addr, mem_waddr;
  logic                         mem_we, rd_en, scan_issue, full, empty, slot_free;
  logic signed [DATA_WIDTH-1:0] mem_wdata;
  logic [CW-1:0]                sat_k, list_k, list_start;

  // Logical position to memory address; the sum stays below twice the depth.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(idx);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign key        = DATA_WIDTH'(op_r);
  assign full       = (count_r == CW'(DEPTH));
  assign empty      = (count_r == '0);
  assign slot_free  = !out_valid_r || out_ready;
  assign head_dec   = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc   = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign scan_issue = cmd.scan_step && (ptr_r != lim_r);
  assign rd_en      = cmd.rd_issue || scan_issue;
  assign rd_addr    = phys(head_r, ptr_r);

  // Listing window: saturate k, clip to the fill level.
  always_comb begin
    if (op_r[VAL_W-1]) begin
      sat_k = '0;
    end else if ($unsigned(op_r) > 32'(DEPTH)) begin
      sat_k = CW'(DEPTH);
    end else begin
      sat_k = op_r[CW-1:0];
    end
    if (req_r == REQ_LIST_ALL || sat_k > count_r) begin
      list_k = count_r;
    end else begin
      list_k = sat_k;
    end
    list_start = (req_r == REQ_LIST_LAST) ? count_r - list_k : '0;
  end

  // Memory write port.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head_dec;
    mem_wdata = key;
    if (cmd.update && !full) begin
      if (req_r == REQ_PUSH_FRONT) begin
        mem_we = 1'b1;
      end else if (req_r == REQ_PUSH_BACK) begin
        mem_we    = 1'b1;
        mem_waddr = phys(head_r, count_r);
      end
    end
    // Close up behind the match: move each later entry one place forward.
    if (cmd.scan_step && rd_vld_r && found_r) begin
      mem_we    = 1'b1;
      mem_waddr = phys(head_r, rd_idx_r - 1'b1);
      mem_wdata = rd_data_r;
    end
  end

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    found_nxt     = found_r;
    rd_vld_nxt    = rd_vld_r;
    resp_nxt      = resp_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_resp || cmd.load_item) out_valid_nxt = 1'b1;
    if (cmd.update) begin
      resp_nxt = STAT_OK;
      unique case (req_r)
        REQ_PUSH_FRONT: begin
          if (full) begin
            resp_nxt = STAT_FULL;
          end else begin
            head_nxt  = head_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        REQ_PUSH_BACK: begin
          if (full) begin
            resp_nxt = STAT_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            resp_nxt = STAT_EMPTY;
          end else begin
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            resp_nxt = STAT_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          count_nxt = '0;
        end
      endcase
    end
    if (cmd.scan_init) begin
      found_nxt  = 1'b0;
      rd_vld_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      rd_vld_nxt = scan_issue;
      if (rd_vld_r && !found_r && rd_data_r == key) found_nxt = 1'b1;
    end
    if (cmd.scan_finish) begin
      if (found_r) begin
        count_nxt = count_r - 1'b1;
        resp_nxt  = STAT_OK;
      end else begin
        resp_nxt = STAT_NOT_FOUND;
      end
    end
    if (cmd.list_init && list_k == '0) resp_nxt = STAT_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      found_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    resp_r <= resp_nxt;
    if (cmd.latch) begin
      req_r <= in_data.req_type;
      op_r  <= in_data.operand_value;
    end
    if (cmd.scan_init) begin
      ptr_r <= '0;
      lim_r <= count_r;
    end
    if (cmd.list_init) begin
      ptr_r <= list_start;
      lim_r <= list_start + list_k;
    end
    if (rd_en) begin
      ptr_r    <= ptr_r + 1'b1;
      rd_idx_r <= ptr_r;
    end
    if (cmd.load_resp) begin
      out_data_r.item_value <= '0;
      out_data_r.status     <= resp_r;
      out_data_r.last_flag  <= 1'b1;
    end
    if (cmd.load_item) begin
      out_data_r.item_value <= VAL_W'(rd_data_r);
      out_data_r.status     <= STAT_OK;
      out_data_r.last_flag  <= (ptr_r == lim_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign sts.req        = req_r;
  assign sts.slot_free  = slot_free;
  assign sts.list_empty = (list_k == '0);
  assign sts.scan_done  = (ptr_r == lim_r) && !rd_vld_r;
  assign sts.list_last  = (ptr_r == lim_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/bounded_deque_with_value_delete_unit.sv
// Top level of the bounded deque unit with delete by value.
//
//   channel | ports                        | carries
//   --------+------------------------------+-------------------------------------
//   input   | in_valid, in_ready, in_data  | one request: req_type, operand_value
//   output  | out_valid, out_ready, out_data | item_value, status, last_flag
//
// One request at a time. Push, pop and clear pass from accept through an execute state
// and a response state, then back to idle; the result is loaded in the response state.
// Listing k entries: each entry is one read of the entry memory and one load of the
// output register; an empty listing loads a status result only. Delete makes one pass
// that reads every entry through the memory read port and closes up behind the match.
// Reset (rst_n low, synchronous) empties the store; memory contents are not cleared.
// A stalled output holds its transaction in the output register; the sequencer waits.
module bounded_deque_with_value_delete_unit
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: accept, dispatch by request, pace the result transactions.
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: circular entry memory with head pointer and fill count.
  bdq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/bdq_chk.sv
// Port-level checks for the bounded deque unit, bound to the top level.
module bdq_chk
  import bdq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.last_flag)
    else $error("status result not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.item_value == '0)
    else $error("status result carries a value");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bounded_deque_with_value_delete_unit bdq_chk u_bdq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
